FILE: src/niu_pkg.sv
package niu_pkg;

  localparam int SampleW  = 32;
  localparam int RatioW   = 20;
  localparam int FracBits = 16;
  localparam int PaddrW   = 3;
  localparam int PdataW   = 32;

  localparam logic signed [RatioW-1:0] RatioOne = RatioW'(1 << FracBits);

  typedef enum logic [1:0] {
    ModeLinear = 2'd0,
    ModeQuad   = 2'd1,
    ModeCubic  = 2'd2,
    ModeBipara = 2'd3
  } blend_mode_e;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_one;
    logic signed [SampleW-1:0] sample_two;
    logic signed [SampleW-1:0] sample_three;
    logic signed [SampleW-1:0] sample_four;
    logic signed [RatioW-1:0]  ratio_one_two;
    logic signed [RatioW-1:0]  ratio_two_three;
    logic signed [RatioW-1:0]  ratio_three_four;
    logic signed [RatioW-1:0]  ratio_one_three;
    logic signed [RatioW-1:0]  ratio_two_four;
    logic signed [RatioW-1:0]  ratio_one_four;
  } niu_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] interpolated;
    logic                      clipped;
  } niu_out_t;

endpackage

FILE: src/niu_blend.sv
module niu_blend #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int RATIO_WIDTH  = 20
) (
  input  logic                           clk_i,
  input  logic [2:0]                     en_i,
  input  logic signed [SAMPLE_WIDTH-1:0] a_i,
  input  logic signed [SAMPLE_WIDTH-1:0] b_i,
  input  logic signed [RATIO_WIDTH-1:0]  r_i,
  output logic signed [SAMPLE_WIDTH-1:0] y_o,
  output logic                           clip_o
);
  import niu_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int RW = RATIO_WIDTH;
  localparam int PW = SW + RW;

  localparam logic signed [SW-1:0] SMax = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMin = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [PW-1:0] PMax = {{RW{1'b0}}, SMax};
  localparam logic signed [PW-1:0] PMin = {{RW{1'b1}}, SMin};

  // stage one: saturated difference
  logic signed [SW:0]   diff;
  logic                 diff_ovf;
  logic signed [SW-1:0] d_d, d_q;
  logic signed [SW-1:0] a1_q;
  logic signed [RW-1:0] r1_q;
  logic                 clip1_q;

  // stage two: full product
  logic signed [PW-1:0] prod_d, prod_q;
  logic signed [SW-1:0] a2_q;
  logic                 clip2_q;

  // stage three: floor, saturate, subtract
  logic signed [PW-1:0] shifted;
  logic                 p_hi, p_lo;
  logic signed [SW-1:0] p_sat;
  logic signed [SW:0]   res;
  logic                 res_ovf;
  logic signed [SW-1:0] y_d, y_q;
  logic                 clip_d, clip_q;

  always_comb begin
    diff     = {a_i[SW-1], a_i} - {b_i[SW-1], b_i};
    diff_ovf = diff[SW] != diff[SW-1];
    if (diff_ovf) begin
      d_d = diff[SW] ? SMin : SMax;
    end else begin
      d_d = diff[SW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      d_q     <= d_d;
      a1_q    <= a_i;
      r1_q    <= r_i;
      clip1_q <= diff_ovf;
    end
  end

  assign prod_d = $signed({{RW{d_q[SW-1]}}, d_q}) * $signed({{SW{r1_q[RW-1]}}, r1_q});

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      prod_q  <= prod_d;
      a2_q    <= a1_q;
      clip2_q <= clip1_q;
    end
  end

  always_comb begin
    shifted = prod_q >>> FracBits;
    p_hi    = shifted > PMax;
    p_lo    = shifted < PMin;
    if (p_hi) begin
      p_sat = SMax;
    end else if (p_lo) begin
      p_sat = SMin;
    end else begin
      p_sat = shifted[SW-1:0];
    end
    res     = {a2_q[SW-1], a2_q} - {p_sat[SW-1], p_sat};
    res_ovf = res[SW] != res[SW-1];
    if (res_ovf) begin
      y_d = res[SW] ? SMin : SMax;
    end else begin
      y_d = res[SW-1:0];
    end
    clip_d = clip2_q | p_hi | p_lo | res_ovf;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      y_q    <= y_d;
      clip_q <= clip_d;
    end
  end

  assign y_o    = y_q;
  assign clip_o = clip_q;

endmodule

FILE: src/neville_interpolation_unit.sv
// pipeline: three chained three-stage blend levels and an output register
// throughput: one word per cycle while the output is not stalled
// a stalled output holds its word; bubbles inside the pipeline still close up
// reset clears all valid bits and sets the mode register to linear
// data registers are not reset
module neville_interpolation_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  niu_pkg::niu_in_t               in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output niu_pkg::niu_out_t              out_word_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [niu_pkg::PaddrW-1:0]     paddr,
  input  logic [niu_pkg::PdataW-1:0]     pwdata,
  output logic [niu_pkg::PdataW-1:0]     prdata,
  output logic                           pready
);
  import niu_pkg::*;

  localparam int Stages = 10;

  typedef struct packed {
    logic signed [RatioW-1:0]  r13;
    logic signed [RatioW-1:0]  r24;
    logic signed [RatioW-1:0]  r14;
    logic signed [RatioW-1:0]  r23;
    logic                      below;
    logic                      above;
    logic signed [SampleW-1:0] p12;
    logic signed [SampleW-1:0] p13;
    logic signed [SampleW-1:0] p24;
    logic                      c12;
    logic                      c23;
    logic                      c34;
    logic                      c13;
    logic                      c24;
  } side_t;

  blend_mode_e mode_q;

  logic [Stages+1:1] en;
  logic [Stages:1]   vld_q, vld_d;
  side_t             side_d [1:9];
  side_t             side_q [1:9];
  niu_out_t          out_d, out_q;

  logic signed [SampleW-1:0] y12, y23, y34, y13, y24, y3;
  logic                      c12, c23, c34, c13, c24, c3;
  logic signed [RatioW-1:0]  r_last;
  logic                      c_lo, c_hi, c_all;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeLinear;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      mode_q <= blend_mode_e'(pwdata[1:0]);
    end
  end

  assign prdata = paddr[2] ? '0 : {{(PdataW-2){1'b0}}, mode_q};

  // pipeline flow control
  always_comb begin
    en[Stages+1] = !out_stall_i;
    for (int k = Stages; k >= 1; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign vld_d      = {vld_q[Stages-1:1], in_valid_i};
  assign in_stall_o = !en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 1; k <= Stages; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  // first level
  niu_blend #(.SAMPLE_WIDTH(SampleW), .RATIO_WIDTH(RatioW)) u_blend_12 (
    .clk_i, .en_i(en[3:1]),
    .a_i(in_word_i.sample_one), .b_i(in_word_i.sample_two),
    .r_i(in_word_i.ratio_one_two), .y_o(y12), .clip_o(c12)
  );

  niu_blend #(.SAMPLE_WIDTH(SampleW), .RATIO_WIDTH(RatioW)) u_blend_23 (
    .clk_i, .en_i(en[3:1]),
    .a_i(in_word_i.sample_two), .b_i(in_word_i.sample_three),
    .r_i(in_word_i.ratio_two_three), .y_o(y23), .clip_o(c23)
  );

  niu_blend #(.SAMPLE_WIDTH(SampleW), .RATIO_WIDTH(RatioW)) u_blend_34 (
    .clk_i, .en_i(en[3:1]),
    .a_i(in_word_i.sample_three), .b_i(in_word_i.sample_four),
    .r_i(in_word_i.ratio_three_four), .y_o(y34), .clip_o(c34)
  );

  // second level
  niu_blend #(.SAMPLE_WIDTH(SampleW), .RATIO_WIDTH(RatioW)) u_blend_13 (
    .clk_i, .en_i(en[6:4]),
    .a_i(y12), .b_i(y23), .r_i(side_q[3].r13), .y_o(y13), .clip_o(c13)
  );

  niu_blend #(.SAMPLE_WIDTH(SampleW), .RATIO_WIDTH(RatioW)) u_blend_24 (
    .clk_i, .en_i(en[6:4]),
    .a_i(y23), .b_i(y34), .r_i(side_q[3].r24), .y_o(y24), .clip_o(c24)
  );

  // third level, cubic or biparabolic mix
  assign r_last = (mode_q == ModeCubic) ? side_q[6].r14 : side_q[6].r23;

  niu_blend #(.SAMPLE_WIDTH(SampleW), .RATIO_WIDTH(RatioW)) u_blend_3 (
    .clk_i, .en_i(en[9:7]),
    .a_i(y13), .b_i(y24), .r_i(r_last), .y_o(y3), .clip_o(c3)
  );

  // side band that travels with each word
  always_comb begin
    side_d[1]       = '0;
    side_d[1].r13   = in_word_i.ratio_one_three;
    side_d[1].r24   = in_word_i.ratio_two_four;
    side_d[1].r14   = in_word_i.ratio_one_four;
    side_d[1].r23   = in_word_i.ratio_two_three;
    side_d[1].below = in_word_i.ratio_two_three[RatioW-1];
    side_d[1].above = in_word_i.ratio_two_three > RatioOne;
    for (int k = 2; k <= 9; k++) begin
      side_d[k] = side_q[k-1];
    end
    side_d[4].p12 = y12;
    side_d[4].c12 = c12;
    side_d[4].c23 = c23;
    side_d[4].c34 = c34;
    side_d[7].p13 = y13;
    side_d[7].p24 = y24;
    side_d[7].c13 = c13;
    side_d[7].c24 = c24;
  end

  always_ff @(posedge clk_i) begin
    for (int k = 1; k <= 9; k++) begin
      if (en[k]) begin
        side_q[k] <= side_d[k];
      end
    end
  end

  // result selection
  always_comb begin
    c_lo  = side_q[9].c12 | side_q[9].c23 | side_q[9].c13;
    c_hi  = side_q[9].c23 | side_q[9].c34 | side_q[9].c24;
    c_all = c_lo | c_hi | c3;
    case (mode_q)
      ModeLinear: begin
        out_d.interpolated = side_q[9].p12;
        out_d.clipped      = side_q[9].c12;
      end
      ModeQuad: begin
        out_d.interpolated = side_q[9].p13;
        out_d.clipped      = c_lo;
      end
      ModeCubic: begin
        out_d.interpolated = y3;
        out_d.clipped      = c_all;
      end
      default: begin
        if (side_q[9].below) begin
          out_d.interpolated = side_q[9].p13;
          out_d.clipped      = c_lo;
        end else if (side_q[9].above) begin
          out_d.interpolated = side_q[9].p24;
          out_d.clipped      = c_hi;
        end else begin
          out_d.interpolated = y3;
          out_d.clipped      = c_all;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[Stages]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q[Stages];
  assign out_word_o  = out_q;

endmodule
